FILE: sv/nbg_pkg.sv
// ============================================================================
// nbg_pkg
// Shared types and constants of the direct-sum gravity step block.
// ============================================================================
package nbg_pkg;

    localparam int unsigned POS_W  = 48;
    localparam int unsigned MASS_W = 32;
    localparam int unsigned GC_W   = 32;
    localparam int unsigned ACC_W  = 64;
    localparam logic [GC_W-1:0] GRAVITY_RESET = 32'd1000000000;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [MASS_W-1:0]       mass_t;
    typedef logic [ACC_W-1:0]        acc_t;

    // Divider unit command
    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
        logic [7:0]   nbits;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

FILE: sv/nbg_div.sv
// ============================================================================
// nbg_div
// Shared restoring divider, one quotient bit per cycle. Returns low 64 bits of
// floor(num / den), num taken as its low nbits bits; den zero yields zero.
// ============================================================================
module nbg_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  nbg_pkg::div_cmd_t cmd,
    output nbg_pkg::div_rsp_t rsp
);
    import nbg_pkg::*;

    logic [127:0] num_reg;
    logic [63:0]  den_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  quo_reg;
    logic [7:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [64:0]  shifted;
    logic [64:0]  diff;

    always_comb
    begin
        shifted = {rem_reg, num_reg[127]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            num_reg <= cmd.num << (8'd128 - cmd.nbits);
            den_reg <= cmd.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[126:0], 1'b0};
            if (den_reg != '0 && !diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (den_reg == '0) ? '0 : quo_reg;

endmodule

FILE: sv/nbg_mul.sv
// ============================================================================
// nbg_mul
// Shared 64x64 multiplier, one 32x32 partial product per cycle, 128-bit result.
// ============================================================================
module nbg_mul
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic          done,
    output logic [127:0]  prod
);
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [2:0]   ph_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  ma;
    logic [31:0]  mb;
    logic [63:0]  pp;
    logic [6:0]   sh_amt;
    logic [127:0] pp_sh;

    always_comb
    begin
        ma = ph_reg[1] ? a_reg[63:32] : a_reg[31:0];
        mb = ph_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = ma * mb;
        sh_amt = {({1'b0, ph_reg[1]} + {1'b0, ph_reg[0]}), 5'd0};
        pp_sh = {64'd0, pp} << sh_amt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: sv/nbody_gravity_step.sv
// ============================================================================
// nbody_gravity_step
// Direct-sum 2D gravity step over up to MAX_PARTICLES loaded particles.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// load     | start / busy        | pos_x pos_y vel_x vel_y mass last
// config   | cfg_valid/cfg_ready | cfg_data (gravity_constant)
// result   | result_valid        | new_pos_x .. out_mass out_last
//
// A non-last item is only stored and the block stays idle. A last item runs
// N*(N-1) pair evaluations on one shared 32x32 multiplier and one bit-serial
// divider (64-step square root search, one 64-bit and two 128-bit quotients);
// a skipped pair goes from S_DIFF straight to S_NEXT. Then N update passes with
// two 64-bit mass divisions each, then one result per particle via S_ORD/S_OUT.
// Reset clears control and sets gravity_constant to 1000000000.
// The receiver cannot stall results.
// ============================================================================
module nbody_gravity_step
#(
    parameter int unsigned MAX_PARTICLES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  nbg_pkg::pos_t       pos_x,
    input  nbg_pkg::pos_t       pos_y,
    input  nbg_pkg::pos_t       vel_x,
    input  nbg_pkg::pos_t       vel_y,
    input  nbg_pkg::mass_t      mass,
    input  logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    output logic                result_valid,
    output nbg_pkg::pos_t       new_pos_x,
    output nbg_pkg::pos_t       new_pos_y,
    output nbg_pkg::pos_t       new_vel_x,
    output nbg_pkg::pos_t       new_vel_y,
    output nbg_pkg::mass_t      out_mass,
    output logic                out_last
);
    import nbg_pkg::*;

    localparam int unsigned IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RDI   = 5'd1;
    localparam logic [4:0] S_RDJ   = 5'd2;
    localparam logic [4:0] S_DIFF  = 5'd3;
    localparam logic [4:0] S_SQX   = 5'd4;
    localparam logic [4:0] S_SQY   = 5'd5;
    localparam logic [4:0] S_P1    = 5'd6;
    localparam logic [4:0] S_P2    = 5'd7;
    localparam logic [4:0] S_Q     = 5'd8;
    localparam logic [4:0] S_RT    = 5'd9;
    localparam logic [4:0] S_RTW   = 5'd10;
    localparam logic [4:0] S_TXM   = 5'd11;
    localparam logic [4:0] S_TXD   = 5'd12;
    localparam logic [4:0] S_TYM   = 5'd13;
    localparam logic [4:0] S_TYD   = 5'd14;
    localparam logic [4:0] S_NEXT  = 5'd15;
    localparam logic [4:0] S_URD   = 5'd16;
    localparam logic [4:0] S_UDX   = 5'd17;
    localparam logic [4:0] S_UDY   = 5'd18;
    localparam logic [4:0] S_UWR   = 5'd19;
    localparam logic [4:0] S_ORD   = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;
    localparam logic [4:0] S_WAIT  = 5'd22;

    pos_t  mem_px [MAX_PARTICLES];
    pos_t  mem_py [MAX_PARTICLES];
    pos_t  mem_vx [MAX_PARTICLES];
    pos_t  mem_vy [MAX_PARTICLES];
    mass_t mem_m  [MAX_PARTICLES];
    pos_t  new_px [MAX_PARTICLES];
    pos_t  new_py [MAX_PARTICLES];
    acc_t  mem_ix [MAX_PARTICLES];
    acc_t  mem_iy [MAX_PARTICLES];

    logic [4:0]      state_reg;
    logic [4:0]      ret_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   j_reg;
    logic [GC_W-1:0] gc_reg;

    pos_t        pix_reg, piy_reg, pjx_reg, pjy_reg;
    pos_t        vx_reg, vy_reg;
    mass_t       mi_reg, mj_reg;
    logic signed [48:0] dx_reg, dy_reg;
    logic [63:0] ay_reg, sq_reg, s_reg, q_reg, r_reg;
    logic [6:0]  bit_reg;
    acc_t        ix_reg, iy_reg;
    logic        skip_reg;

    logic         mul_start;
    logic [63:0]  mul_a, mul_b;
    logic         mul_done;
    logic [127:0] mul_p;
    div_cmd_t     dcmd;
    div_rsp_t     drsp;

    logic [63:0]  rt_try;
    logic [63:0]  negq;
    logic [64:0]  s_sum;
    logic [63:0]  ax_abs;
    logic [63:0]  ay_abs;

    nbg_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    nbg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dcmd),
        .rsp   (drsp)
    );

    assign rt_try    = r_reg | (64'd1 << bit_reg[5:0]);
    assign s_sum     = {1'b0, sq_reg} + {1'b0, mul_p[63:0]};
    assign negq      = 64'd0 - drsp.quo;
    assign ax_abs    = dx_reg[48] ? 64'(-dx_reg) : 64'(dx_reg);
    assign ay_abs    = dy_reg[48] ? 64'(-dy_reg) : 64'(dy_reg);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        dcmd       = '0;
        unique case (state_reg)
            S_DIFF:
            begin
                mul_start = 1'b1;
                mul_a = ax_abs;
                mul_b = ax_abs;
            end
            S_SQX:
            begin
                mul_start = mul_done;
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_SQY:
            begin
                mul_start = mul_done && !s_sum[64];
                mul_a = {32'd0, gc_reg};
                mul_b = {32'd0, mi_reg};
            end
            S_P1:
            begin
                mul_start = mul_done;
                mul_a = {32'd0, mul_p[31:0]};
                mul_b = {32'd0, mj_reg};
            end
            S_P2:
            begin
                dcmd.start = mul_done;
                dcmd.num   = {64'd0, mul_p[31:0], 32'd0};
                dcmd.den   = s_reg;
                dcmd.nbits = 8'd64;
            end
            S_RT:
            begin
                mul_start = 1'b1;
                mul_a = rt_try;
                mul_b = rt_try;
            end
            S_TXM:
            begin
                mul_start = 1'b1;
                mul_a = dx_reg[48] ? 64'(-dx_reg) : 64'(dx_reg);
                mul_b = q_reg;
            end
            S_TXD:
            begin
                dcmd.start = mul_done;
                dcmd.num   = mul_p;
                dcmd.den   = r_reg;
                dcmd.nbits = 8'd128;
            end
            S_TYM:
            begin
                mul_start = 1'b1;
                mul_a = dy_reg[48] ? 64'(-dy_reg) : 64'(dy_reg);
                mul_b = q_reg;
            end
            S_TYD:
            begin
                dcmd.start = mul_done;
                dcmd.num   = mul_p;
                dcmd.den   = r_reg;
                dcmd.nbits = 8'd128;
            end
            S_URD:
            begin
                dcmd.start = 1'b1;
                dcmd.num   = {64'd0, ix_reg[63] ? 64'd0 - ix_reg : ix_reg};
                dcmd.den   = {32'd0, mi_reg};
                dcmd.nbits = 8'd64;
            end
            S_UDX:
            begin
                dcmd.start = drsp.done;
                dcmd.num   = {64'd0, iy_reg[63] ? 64'd0 - iy_reg : iy_reg};
                dcmd.den   = {32'd0, mi_reg};
                dcmd.nbits = 8'd64;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && count_reg < CW'(MAX_PARTICLES))
        begin
            mem_px[count_reg[IW-1:0]] <= pos_x;
            mem_py[count_reg[IW-1:0]] <= pos_y;
            mem_vx[count_reg[IW-1:0]] <= vel_x;
            mem_vy[count_reg[IW-1:0]] <= vel_y;
            mem_m[count_reg[IW-1:0]]  <= mass;
        end
        if (state_reg == S_RDI)
        begin
            pix_reg <= mem_px[i_reg[IW-1:0]];
            piy_reg <= mem_py[i_reg[IW-1:0]];
            mi_reg  <= mem_m[i_reg[IW-1:0]];
            ix_reg  <= '0;
            iy_reg  <= '0;
        end
        if (state_reg == S_RDJ)
        begin
            pjx_reg <= mem_px[j_reg[IW-1:0]];
            pjy_reg <= mem_py[j_reg[IW-1:0]];
            mj_reg  <= mem_m[j_reg[IW-1:0]];
        end
        if (state_reg == S_TXD && drsp.done)
            ix_reg <= ix_reg + (dx_reg[48] ? negq : drsp.quo);
        if (state_reg == S_TYD && drsp.done)
            iy_reg <= iy_reg + (dy_reg[48] ? negq : drsp.quo);
        if (state_reg == S_NEXT && j_reg + CW'(1) >= count_reg)
        begin
            mem_ix[i_reg[IW-1:0]] <= ix_reg;
            mem_iy[i_reg[IW-1:0]] <= iy_reg;
        end
        if (state_reg == S_WAIT && ret_reg == S_URD)
        begin
            ix_reg <= mem_ix[i_reg[IW-1:0]];
            iy_reg <= mem_iy[i_reg[IW-1:0]];
            vx_reg <= mem_vx[i_reg[IW-1:0]];
            vy_reg <= mem_vy[i_reg[IW-1:0]];
            pix_reg <= mem_px[i_reg[IW-1:0]];
            piy_reg <= mem_py[i_reg[IW-1:0]];
            mi_reg  <= mem_m[i_reg[IW-1:0]];
        end
        if (state_reg == S_UDX && drsp.done)
            vx_reg <= vx_reg - (ix_reg[63] ? 48'(negq) : 48'(drsp.quo));
        if (state_reg == S_UDY && drsp.done)
            vy_reg <= vy_reg - (iy_reg[63] ? 48'(negq) : 48'(drsp.quo));
        if (state_reg == S_UWR)
        begin
            mem_vx[i_reg[IW-1:0]] <= vx_reg;
            mem_vy[i_reg[IW-1:0]] <= vy_reg;
            new_px[i_reg[IW-1:0]] <= pix_reg + vx_reg;
            new_py[i_reg[IW-1:0]] <= piy_reg + vy_reg;
        end
        if (state_reg == S_ORD)
        begin
            new_pos_x <= new_px[i_reg[IW-1:0]];
            new_pos_y <= new_py[i_reg[IW-1:0]];
            new_vel_x <= mem_vx[i_reg[IW-1:0]];
            new_vel_y <= mem_vy[i_reg[IW-1:0]];
            out_mass  <= mem_m[i_reg[IW-1:0]];
            out_last  <= (i_reg + CW'(1) == count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            gc_reg       <= GRAVITY_RESET;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        gc_reg <= cfg_data;
                    if (start)
                    begin
                        if (count_reg < CW'(MAX_PARTICLES))
                            count_reg <= count_reg + CW'(1);
                        if (last)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_RDI;
                        end
                    end
                end
                S_RDI:
                begin
                    j_reg  <= '0;
                    state_reg <= S_RDJ;
                end
                S_RDJ:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (ret_reg == S_URD)
                        state_reg <= S_URD;
                    else
                    begin
                        dx_reg <= 49'(pix_reg) - 49'(pjx_reg);
                        dy_reg <= 49'(piy_reg) - 49'(pjy_reg);
                        skip_reg  <= (j_reg == i_reg);
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    ay_reg <= ay_abs;
                    if (skip_reg || (dx_reg == '0 && dy_reg == '0)
                        || ax_abs > 64'hFFFF_FFFF
                        || ay_abs > 64'hFFFF_FFFF)
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_SQX;
                end
                S_SQX:
                begin
                    if (mul_done)
                    begin
                        sq_reg <= mul_p[63:0];
                        state_reg <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    if (mul_done)
                    begin
                        s_reg <= s_sum[63:0];
                        state_reg <= s_sum[64] ? S_NEXT : S_P1;
                    end
                end
                S_P1:
                    if (mul_done)
                        state_reg <= S_P2;
                S_P2:
                    if (drsp.done)
                    begin
                        q_reg   <= drsp.quo;
                        r_reg   <= '0;
                        bit_reg <= 7'd63;
                        state_reg <= S_RT;
                    end
                S_Q:
                    state_reg <= S_RT;
                S_RT:
                    state_reg <= S_RTW;
                S_RTW:
                    if (mul_done)
                    begin
                        if (mul_p[127:64] < s_reg || (mul_p[127:64] == s_reg && mul_p[63:0] == '0))
                            r_reg <= rt_try;
                        if (bit_reg == 7'd0)
                            state_reg <= S_TXM;
                        else
                        begin
                            bit_reg   <= bit_reg - 7'd1;
                            state_reg <= S_RT;
                        end
                    end
                S_TXM:
                    state_reg <= S_TXD;
                S_TXD:
                    if (drsp.done)
                        state_reg <= S_TYM;
                S_TYM:
                    state_reg <= S_TYD;
                S_TYD:
                    if (drsp.done)
                        state_reg <= S_NEXT;
                S_NEXT:
                begin
                    if (j_reg + CW'(1) < count_reg)
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_RDJ;
                    end
                    else if (i_reg + CW'(1) < count_reg)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_RDI;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        ret_reg   <= S_URD;
                        state_reg <= S_WAIT;
                    end
                end
                S_URD:
                    state_reg <= S_UDX;
                S_UDX:
                    if (drsp.done)
                        state_reg <= S_UDY;
                S_UDY:
                    if (drsp.done)
                        state_reg <= S_UWR;
                S_UWR:
                begin
                    if (i_reg + CW'(1) < count_reg)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        ret_reg   <= S_IDLE;
                        state_reg <= S_ORD;
                    end
                end
                S_ORD:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    result_valid <= 1'b1;
                    if (i_reg + CW'(1) < count_reg)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        count_reg <= '0;
                        i_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
